@@ hdl/spbo_pkg.sv @@
// ----------------------------------------------------------------------------
// spbo_pkg
// Shared types, constants and geometry helpers for the box overlap broadphase.
// ----------------------------------------------------------------------------
package spbo_pkg;

  localparam int unsigned MaxBoxesDef    = 64;
  localparam int unsigned MaxContactsDef = 64;

  localparam logic ModeLoad = 1'b0;
  localparam logic ModeRun  = 1'b1;

  localparam logic AxisX = 1'b0;
  localparam logic AxisY = 1'b1;

  typedef struct packed {
    logic [15:0]        id;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic [14:0]        hw;
    logic [14:0]        hh;
    logic [63:0]        mask;
    logic [63:0]        group;
  } box_t;

  // control from the sequencer to the variance unit
  typedef struct packed {
    logic               ld;
    logic               start;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
  } var_req_t;

  function automatic logic signed [16:0] lower_edge(box_t b, logic axis);
    logic signed [16:0] c;
    logic signed [16:0] h;
    begin
      c = (axis == AxisY) ? $signed({b.cy[15], b.cy}) : $signed({b.cx[15], b.cx});
      h = (axis == AxisY) ? $signed({2'b00, b.hh}) : $signed({2'b00, b.hw});
      return c - h;
    end
  endfunction

  function automatic logic signed [16:0] upper_edge(box_t b, logic axis);
    logic signed [16:0] c;
    logic signed [16:0] h;
    begin
      c = (axis == AxisY) ? $signed({b.cy[15], b.cy}) : $signed({b.cx[15], b.cx});
      h = (axis == AxisY) ? $signed({2'b00, b.hh}) : $signed({2'b00, b.hw});
      return c + h;
    end
  endfunction

  function automatic logic excluded(box_t a, box_t b);
    return ((a.mask & b.group) != 64'd0) || ((a.group & b.mask) != 64'd0);
  endfunction

  function automatic logic axis_hit(logic signed [15:0] ca, logic signed [15:0] cb,
                                    logic [14:0] ha, logic [14:0] hb);
    logic signed [16:0] d;
    logic [16:0]        ad;
    logic [15:0]        s;
    begin
      d  = $signed({ca[15], ca}) - $signed({cb[15], cb});
      ad = d[16] ? 17'(-d) : 17'(d);
      s  = {1'b0, ha} + {1'b0, hb};
      return ad <= {1'b0, s};
    end
  endfunction

  function automatic logic overlap(box_t a, box_t b);
    return axis_hit(a.cx, b.cx, a.hw, b.hw) && axis_hit(a.cy, b.cy, a.hh, b.hh);
  endfunction

endpackage

@@ hdl/spbo_box_store.sv @@
// ----------------------------------------------------------------------------
// spbo_box_store
// Box memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spbo_box_store #(
  parameter int unsigned MAX_BOXES = spbo_pkg::MaxBoxesDef
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [$clog2(MAX_BOXES)-1:0] waddr_i,
  input  spbo_pkg::box_t               wdata_i,
  input  logic [$clog2(MAX_BOXES)-1:0] raddr_i,
  output spbo_pkg::box_t               rdata_o
);

  spbo_pkg::box_t mem [MAX_BOXES];
  spbo_pkg::box_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/spbo_var_unit.sv @@
// ----------------------------------------------------------------------------
// spbo_var_unit
// Accumulates center sums per load and picks the axis of larger spread.
// ----------------------------------------------------------------------------
module spbo_var_unit #(
  parameter int unsigned MAX_BOXES = spbo_pkg::MaxBoxesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  spbo_pkg::var_req_t             req_i,
  input  logic [$clog2(MAX_BOXES+1)-1:0] n_i,
  output logic                           axis_o
);

  localparam int unsigned CW  = $clog2(MAX_BOXES + 1);
  localparam int unsigned S1W = 16 + CW;
  localparam int unsigned S2W = 31 + CW;
  localparam int unsigned VW  = 31 + 2 * CW;

  logic                  pv_q, st1_q, st2_q, axis_q;
  logic signed [15:0]    cx_q, cy_q;
  logic [30:0]           px_q, py_q;
  logic signed [S1W-1:0] s1x_q, s1y_q;
  logic [S2W-1:0]        s2x_q, s2y_q;
  logic [VW-1:0]         mx_q, my_q, qx_q, qy_q, vx_q, vy_q;
  logic signed [31:0]    sqcx, sqcy;
  logic signed [2*S1W-1:0] sq1x, sq1y;

  assign sqcx = 32'(req_i.cx) * 32'(req_i.cx);
  assign sqcy = 32'(req_i.cy) * 32'(req_i.cy);
  assign sq1x = (2*S1W)'(s1x_q) * (2*S1W)'(s1x_q);
  assign sq1y = (2*S1W)'(s1y_q) * (2*S1W)'(s1y_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q   <= 1'b0;
      st1_q  <= 1'b0;
      st2_q  <= 1'b0;
      axis_q <= spbo_pkg::AxisY;
      s1x_q  <= '0;
      s1y_q  <= '0;
      s2x_q  <= '0;
      s2y_q  <= '0;
    end else begin
      pv_q  <= req_i.ld;
      st1_q <= req_i.start;
      st2_q <= st1_q;
      if (req_i.start) begin
        s1x_q <= '0;
        s1y_q <= '0;
        s2x_q <= '0;
        s2y_q <= '0;
      end else if (pv_q) begin
        s1x_q <= s1x_q + S1W'(cx_q);
        s1y_q <= s1y_q + S1W'(cy_q);
        s2x_q <= s2x_q + S2W'(px_q);
        s2y_q <= s2y_q + S2W'(py_q);
      end
      if (st2_q) begin
        axis_q <= (vx_q > vy_q) ? spbo_pkg::AxisX : spbo_pkg::AxisY;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ld) begin
      cx_q <= req_i.cx;
      cy_q <= req_i.cy;
      px_q <= sqcx[30:0];
      py_q <= sqcy[30:0];
    end
    if (req_i.start) begin
      mx_q <= VW'(n_i) * VW'(s2x_q);
      my_q <= VW'(n_i) * VW'(s2y_q);
      qx_q <= VW'(sq1x);
      qy_q <= VW'(sq1y);
    end
    // n*sum(c^2) >= (sum c)^2, so the difference never goes negative
    if (st1_q) begin
      vx_q <= mx_q - qx_q;
      vy_q <= my_q - qy_q;
    end
  end

  assign axis_o = axis_q;

endmodule

@@ hdl/sweep_prune_box_overlap_top.sv @@
// ----------------------------------------------------------------------------
// sweep_prune_box_overlap_top
// Box store with rank sort, sweep and buffered contact emission.
// ----------------------------------------------------------------------------
// Load request: one result; no new request is taken until that result is taken.
// Run request: rank sort over the single box memory read port, then a sweep
// over the rank order, then each contact is emitted from the contact buffer.
// Reset: store empty, sort axis x; memory contents are not cleared.
module sweep_prune_box_overlap_top #(
  parameter int unsigned MAX_BOXES    = spbo_pkg::MaxBoxesDef,
  parameter int unsigned MAX_CONTACTS = spbo_pkg::MaxContactsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [15:0] box_id_i,
  input  logic signed [15:0] center_x_i,
  input  logic signed [15:0] center_y_i,
  input  logic [14:0] half_width_i,
  input  logic [14:0] half_height_i,
  input  logic [63:0] mask_bits_i,
  input  logic [63:0] group_bits_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] first_id_o,
  output logic [15:0] second_id_o,
  output logic        pair_valid_o,
  output logic        overflow_o,
  output logic        axis_used_o,
  output logic        last_o
);

  localparam int unsigned IW = $clog2(MAX_BOXES);
  localparam int unsigned CW = $clog2(MAX_BOXES + 1);
  localparam int unsigned HW = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;
  localparam int unsigned FW = $clog2(MAX_CONTACTS + 2);

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_RESP,
    S_RK_I, S_RK_IW, S_RK_J, S_RK_JW, S_RK_WR,
    S_SW_I, S_SW_IO, S_SW_IA, S_SW_J, S_SW_JO, S_SW_JB,
    S_DONE, S_EM_RD, S_EM_W, S_EM_OUT
  } state_e;

  state_e             state_q;
  logic [CW-1:0]      count_q, n_q;
  logic [IW-1:0]      i_q, j_q, rank_q;
  logic [FW-1:0]      found_q, emit_n_q;
  logic [HW-1:0]      k_q;
  logic               sort_axis_q, axis_q, ovf_q;
  logic signed [16:0] key_q;
  spbo_pkg::box_t     a_q;

  logic               out_valid_q, pair_valid_q, overflow_q, axis_used_q, last_q;
  logic [15:0]        first_id_q, second_id_q;

  // memories
  logic [IW-1:0]      order_mem [MAX_BOXES];
  logic [IW-1:0]      ord_rdata_q;
  logic [31:0]        hit_mem [MAX_CONTACTS];
  logic [31:0]        hit_rdata_q;

  logic               in_acc, full;
  logic               st_we;
  logic [IW-1:0]      st_raddr;
  spbo_pkg::box_t     st_wdata, st_rdata;
  logic               ord_we, hit_we;
  logic [IW-1:0]      ord_raddr;
  spbo_pkg::var_req_t var_req;
  logic               var_axis;

  logic signed [16:0] kj;
  logic               rk_less, rk_last, sw_excl, sw_brk, sw_hit, sw_jlast, em_last;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign full       = (count_q == CW'(MAX_BOXES));

  assign st_wdata = '{id: box_id_i, cx: center_x_i, cy: center_y_i, hw: half_width_i,
                      hh: half_height_i, mask: mask_bits_i, group: group_bits_i};

  assign kj       = spbo_pkg::lower_edge(st_rdata, axis_q);
  assign rk_less  = (kj < key_q) || ((kj == key_q) && (j_q < i_q));
  assign rk_last  = (CW'(j_q) + CW'(1) == n_q);
  assign sw_excl  = spbo_pkg::excluded(a_q, st_rdata);
  assign sw_brk   = spbo_pkg::lower_edge(st_rdata, axis_q) >
                    spbo_pkg::upper_edge(a_q, axis_q);
  assign sw_hit   = !sw_excl && !sw_brk && spbo_pkg::overlap(a_q, st_rdata);
  assign sw_jlast = (CW'(j_q) + CW'(1) == n_q);
  assign em_last  = (FW'(k_q) + FW'(1) == emit_n_q);

  always_comb begin
    st_we     = in_acc && (mode_i == spbo_pkg::ModeLoad) && !full;
    ord_we    = (state_q == S_RK_WR);
    hit_we    = (state_q == S_SW_JB) && sw_hit && (found_q < FW'(MAX_CONTACTS));
    ord_raddr = (state_q == S_SW_J) ? j_q : i_q;
    case (state_q)
      S_RK_I:  st_raddr = i_q;
      S_RK_J:  st_raddr = j_q;
      S_SW_IO: st_raddr = ord_rdata_q;
      S_SW_JO: st_raddr = ord_rdata_q;
      default: st_raddr = '0;
    endcase
    var_req.ld    = st_we;
    var_req.start = in_acc && (mode_i == spbo_pkg::ModeRun);
    var_req.cx    = center_x_i;
    var_req.cy    = center_y_i;
  end

  spbo_box_store #(
    .MAX_BOXES(MAX_BOXES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (count_q[IW-1:0]),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  spbo_var_unit #(
    .MAX_BOXES(MAX_BOXES)
  ) u_var (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (var_req),
    .n_i    (count_q),
    .axis_o (var_axis)
  );

  always_ff @(posedge clk_i) begin
    if (ord_we) begin
      order_mem[rank_q] <= i_q;
    end
    ord_rdata_q <= order_mem[ord_raddr];
    if (hit_we) begin
      hit_mem[found_q[HW-1:0]] <= {a_q.id, st_rdata.id};
    end
    hit_rdata_q <= hit_mem[k_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      sort_axis_q  <= spbo_pkg::AxisX;
      out_valid_q  <= 1'b0;
      n_q          <= '0;
      i_q          <= '0;
      j_q          <= '0;
      rank_q       <= '0;
      found_q      <= '0;
      emit_n_q     <= '0;
      k_q          <= '0;
      axis_q       <= spbo_pkg::AxisX;
      ovf_q        <= 1'b0;
      key_q        <= '0;
      a_q          <= '0;
      pair_valid_q <= 1'b0;
      overflow_q   <= 1'b0;
      axis_used_q  <= 1'b0;
      last_q       <= 1'b0;
      first_id_q   <= '0;
      second_id_q  <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            axis_q <= sort_axis_q;
            if (mode_i == spbo_pkg::ModeLoad) begin
              ovf_q <= full;
              if (!full) begin
                count_q <= count_q + CW'(1);
              end
              state_q <= S_LOAD;
            end else begin
              n_q     <= count_q;
              count_q <= '0;
              i_q     <= '0;
              found_q <= '0;
              if (count_q == '0) begin
                ovf_q   <= 1'b0;
                state_q <= S_LOAD;
              end else begin
                state_q <= S_RK_I;
              end
            end
          end
        end
        // single result: load ack, empty run, or run without contacts
        S_LOAD: begin
          first_id_q   <= '0;
          second_id_q  <= '0;
          pair_valid_q <= 1'b0;
          overflow_q   <= ovf_q;
          axis_used_q  <= axis_q;
          last_q       <= 1'b1;
          out_valid_q  <= 1'b1;
          state_q      <= S_RESP;
        end
        S_RESP: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        S_RK_I: state_q <= S_RK_IW;
        S_RK_IW: begin
          key_q   <= spbo_pkg::lower_edge(st_rdata, axis_q);
          j_q     <= '0;
          rank_q  <= '0;
          state_q <= S_RK_J;
        end
        S_RK_J: state_q <= S_RK_JW;
        S_RK_JW: begin
          if (rk_less) begin
            rank_q <= rank_q + IW'(1);
          end
          if (rk_last) begin
            state_q <= S_RK_WR;
          end else begin
            j_q     <= j_q + IW'(1);
            state_q <= S_RK_J;
          end
        end
        S_RK_WR: begin
          if (CW'(i_q) + CW'(1) == n_q) begin
            i_q     <= '0;
            state_q <= S_SW_I;
          end else begin
            i_q     <= i_q + IW'(1);
            state_q <= S_RK_I;
          end
        end
        S_SW_I: state_q <= S_SW_IO;
        S_SW_IO: begin
          j_q     <= i_q + IW'(1);
          state_q <= S_SW_IA;
        end
        S_SW_IA: begin
          a_q <= st_rdata;
          if (CW'(i_q) + CW'(1) == n_q) begin
            state_q <= S_DONE;
          end else begin
            state_q <= S_SW_J;
          end
        end
        S_SW_J:  state_q <= S_SW_JO;
        S_SW_JO: state_q <= S_SW_JB;
        S_SW_JB: begin
          if (sw_hit && (found_q <= FW'(MAX_CONTACTS))) begin
            found_q <= found_q + FW'(1);
          end
          if ((!sw_excl && sw_brk) || sw_jlast) begin
            i_q     <= i_q + IW'(1);
            state_q <= S_SW_I;
          end else begin
            j_q     <= j_q + IW'(1);
            state_q <= S_SW_J;
          end
        end
        S_DONE: begin
          sort_axis_q <= var_axis;
          k_q         <= '0;
          if (found_q == '0) begin
            ovf_q   <= 1'b0;
            state_q <= S_LOAD;
          end else begin
            ovf_q    <= (found_q > FW'(MAX_CONTACTS));
            emit_n_q <= (found_q > FW'(MAX_CONTACTS)) ? FW'(MAX_CONTACTS) : found_q;
            state_q  <= S_EM_RD;
          end
        end
        S_EM_RD: state_q <= S_EM_W;
        S_EM_W: begin
          first_id_q   <= hit_rdata_q[31:16];
          second_id_q  <= hit_rdata_q[15:0];
          pair_valid_q <= 1'b1;
          overflow_q   <= em_last && ovf_q;
          axis_used_q  <= axis_q;
          last_q       <= em_last;
          out_valid_q  <= 1'b1;
          state_q      <= S_EM_OUT;
        end
        S_EM_OUT: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            if (last_q) begin
              state_q <= S_IDLE;
            end else begin
              k_q     <= k_q + HW'(1);
              state_q <= S_EM_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign first_id_o   = first_id_q;
  assign second_id_o  = second_id_q;
  assign pair_valid_o = pair_valid_q;
  assign overflow_o   = overflow_q;
  assign axis_used_o  = axis_used_q;
  assign last_o       = last_q;

endmodule

@@ sim/spbo_contact_checker.sv @@
// ----------------------------------------------------------------------------
// spbo_contact_checker
// Watches the request and result channels of the box overlap broadphase,
// predicts contact pairs for every accepted request and compares them in order.
// ----------------------------------------------------------------------------
module spbo_contact_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        mode_i,
  input  logic [15:0] box_id_i,
  input  logic signed [15:0] center_x_i,
  input  logic signed [15:0] center_y_i,
  input  logic [14:0] half_width_i,
  input  logic [14:0] half_height_i,
  input  logic [63:0] mask_bits_i,
  input  logic [63:0] group_bits_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [15:0] first_id_i,
  input  logic [15:0] second_id_i,
  input  logic        pair_valid_i,
  input  logic        overflow_i,
  input  logic        axis_used_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumBoxes    = spbo_pkg::MaxBoxesDef;
  localparam int unsigned NumContacts = spbo_pkg::MaxContactsDef;

  typedef struct packed {
    logic [15:0] first_id;
    logic [15:0] second_id;
    logic        pair_valid;
    logic        overflow;
    logic        axis_used;
    logic        last;
  } contact_t;

  spbo_pkg::box_t stored_boxes[NumBoxes];
  int       stored_count;
  logic     cur_axis;
  contact_t expected_contacts[$];
  int       mismatches;

  assign fail_count_o = mismatches;
  assign pending_o    = expected_contacts.size();

  function automatic int edge_lo(spbo_pkg::box_t b, logic ax);
    return ax ? int'(b.cy) - int'(b.hh) : int'(b.cx) - int'(b.hw);
  endfunction

  function automatic int edge_hi(spbo_pkg::box_t b, logic ax);
    return ax ? int'(b.cy) + int'(b.hh) : int'(b.cx) + int'(b.hw);
  endfunction

  function automatic bit boxes_touch(spbo_pkg::box_t a, spbo_pkg::box_t b);
    int dx, dy;
    dx = int'(a.cx) - int'(b.cx);
    dy = int'(a.cy) - int'(b.cy);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return dx <= int'(a.hw) + int'(b.hw) && dy <= int'(a.hh) + int'(b.hh);
  endfunction

  task automatic predict_request(logic run, spbo_pkg::box_t nb);
    contact_t c;
    int order[$];
    int hits_a[$], hits_b[$];
    int found, j, t;
    longint s1x, s1y, s2x, s2y, vx, vy;
    spbo_pkg::box_t a, b;
    logic ax;
    c = '0;
    if (run == spbo_pkg::ModeLoad) begin
      if (stored_count < NumBoxes) begin
        stored_boxes[stored_count] = nb;
        stored_count++;
      end else c.overflow = 1'b1;
      c.axis_used = cur_axis;
      c.last = 1'b1;
      expected_contacts.push_back(c);
      return;
    end
    ax = cur_axis;
    c.axis_used = ax;
    c.last = 1'b1;
    if (stored_count == 0) begin
      expected_contacts.push_back(c);
      return;
    end
    // stable insertion sort by lower edge
    for (int i = 0; i < stored_count; i++) begin
      t = i;
      j = order.size();
      while (j > 0 && edge_lo(stored_boxes[order[j-1]], ax) >
                      edge_lo(stored_boxes[t], ax)) j--;
      order.insert(j, t);
    end
    found = 0;
    s1x = 0; s1y = 0; s2x = 0; s2y = 0;
    for (int i = 0; i < stored_count; i++) begin
      a = stored_boxes[order[i]];
      s1x += a.cx; s1y += a.cy;
      s2x += longint'(a.cx) * a.cx;
      s2y += longint'(a.cy) * a.cy;
      for (int k = i + 1; k < stored_count; k++) begin
        b = stored_boxes[order[k]];
        if ((a.mask & b.group) != 0 || (a.group & b.mask) != 0) continue;
        if (edge_lo(b, ax) > edge_hi(a, ax)) break;
        if (boxes_touch(a, b)) begin
          if (found < NumContacts) begin
            hits_a.push_back(a.id);
            hits_b.push_back(b.id);
          end
          found++;
        end
      end
    end
    vx = longint'(stored_count) * s2x - s1x * s1x;
    vy = longint'(stored_count) * s2y - s1y * s1y;
    cur_axis = (vx > vy) ? spbo_pkg::AxisX : spbo_pkg::AxisY;
    stored_count = 0;
    if (found == 0) begin
      expected_contacts.push_back(c);
      return;
    end
    for (int i = 0; i < hits_a.size(); i++) begin
      c = '0;
      c.first_id   = hits_a[i];
      c.second_id  = hits_b[i];
      c.pair_valid = 1'b1;
      c.axis_used  = ax;
      c.last       = (i == hits_a.size() - 1);
      c.overflow   = c.last && (found > NumContacts);
      expected_contacts.push_back(c);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    spbo_pkg::box_t nb;
    contact_t got, want;
    if (!rst_ni) begin
      stored_count = 0;
      cur_axis = spbo_pkg::AxisX;
      mismatches = 0;
      expected_contacts.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        nb = '{id: box_id_i, cx: center_x_i, cy: center_y_i, hw: half_width_i,
               hh: half_height_i, mask: mask_bits_i, group: group_bits_i};
        predict_request(mode_i, nb);
      end
      if (out_valid_i && out_ready_i) begin
        got = '{first_id: first_id_i, second_id: second_id_i,
                pair_valid: pair_valid_i, overflow: overflow_i,
                axis_used: axis_used_i, last: last_i};
        if (expected_contacts.size() == 0) begin
          if (mismatches < 10) $display("unexpected result %p", got);
          mismatches++;
        end else begin
          want = expected_contacts.pop_front();
          if (got !== want) begin
            if (mismatches < 10) $display("mismatch: expected %p actual %p", want, got);
            mismatches++;
          end
        end
      end
    end
  end
endmodule

@@ sim/sweep_prune_box_overlap_top_tb.sv @@
// ----------------------------------------------------------------------------
// sweep_prune_box_overlap_top_tb
// Directed and random box loads and detection runs with random idling on both
// channels and a long result stall; the checker does all comparison.
// ----------------------------------------------------------------------------
module sweep_prune_box_overlap_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 3_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        mode_i = spbo_pkg::ModeLoad;
  logic [15:0] box_id_i = '0;
  logic signed [15:0] center_x_i = '0;
  logic signed [15:0] center_y_i = '0;
  logic [14:0] half_width_i = '0;
  logic [14:0] half_height_i = '0;
  logic [63:0] mask_bits_i = '0;
  logic [63:0] group_bits_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] first_id_o, second_id_o;
  logic        pair_valid_o, overflow_o, axis_used_o, last_o;
  int          fail_count, pending;
  int          cycle_count = 0;
  bit          calm_phase = 1'b0;
  bit          hold_results = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  sweep_prune_box_overlap_top u_dut (.*);

  spbo_contact_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .mode_i, .box_id_i,
    .center_x_i, .center_y_i, .half_width_i, .half_height_i, .mask_bits_i,
    .group_bits_i, .out_valid_i(out_valid_o), .out_ready_i,
    .first_id_i(first_id_o), .second_id_i(second_id_o),
    .pair_valid_i(pair_valid_o), .overflow_i(overflow_o),
    .axis_used_i(axis_used_o), .last_i(last_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stall bursts, or a long hold when asked
  always @(posedge clk_i) begin
    int gap;
    if (rst_ni) begin
      if (hold_results) out_ready_i <= 1'b0;
      else if (calm_phase || $urandom_range(0, 3) != 0) out_ready_i <= 1'b1;
      else begin
        gap = $urandom_range(1, 7);
        out_ready_i <= 1'b0;
        repeat (gap - 1) @(posedge clk_i);
      end
    end
  end

  // valid stays up between back-to-back requests; it drops only for idling
  task automatic send_request(logic m, logic [15:0] id, logic signed [15:0] cx,
                              logic signed [15:0] cy, logic [14:0] hw,
                              logic [14:0] hh, logic [63:0] mk, logic [63:0] gr);
    int gap;
    if (!calm_phase && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= m; box_id_i <= id; center_x_i <= cx; center_y_i <= cy;
    half_width_i <= hw; half_height_i <= hh; mask_bits_i <= mk; group_bits_i <= gr;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic load_random_box(int spread);
    logic [63:0] mk, gr;
    mk = $urandom_range(0, 3) == 0 ? {$urandom, $urandom} : 64'd0;
    gr = $urandom_range(0, 3) == 0 ? {$urandom, $urandom} : 64'd0;
    if ($urandom_range(0, 1)) begin
      mk = mk & (64'd1 << $urandom_range(0, 63));
      gr = gr & (64'd1 << $urandom_range(0, 63));
    end
    send_request(spbo_pkg::ModeLoad, 16'($urandom),
                 16'($urandom_range(0, 2 * spread) - spread),
                 16'($urandom_range(0, 2 * spread) - spread),
                 15'($urandom_range(0, spread / 2)), 15'($urandom_range(0, spread / 2)),
                 mk, gr);
  endtask

  initial begin
    int nb, spread, sent;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: empty run, extremes, exclusion, touching and tied edges
    send_request(spbo_pkg::ModeRun, '1, '1, '1, '1, '1, '1, '1);
    send_request(spbo_pkg::ModeLoad, 16'hFFFF, 16'sh7FFF, 16'sh8000, 15'h7FFF, 15'h7FFF,
                 '1, '0);
    send_request(spbo_pkg::ModeLoad, 16'h0000, 16'sh8000, 16'sh7FFF, 15'h7FFF, 15'h7FFF,
                 '0, '1);
    send_request(spbo_pkg::ModeLoad, 16'h0001, 16'sh8000, 16'sh8000, 15'h7FFF, 15'h0000,
                 '0, '0);
    send_request(spbo_pkg::ModeLoad, 16'h0002, 16'sh7FFF, 16'sh7FFF, 15'h0000, 15'h7FFF,
                 '0, '0);
    send_request(spbo_pkg::ModeRun, '0, '0, '0, '0, '0, '0, '0);
    send_request(spbo_pkg::ModeLoad, 16'h0010, 16'sd0, 16'sd0, 15'd16, 15'd16, '0, '0);
    send_request(spbo_pkg::ModeLoad, 16'h0011, 16'sd32, 16'sd0, 15'd16, 15'd16, '0, '0);
    send_request(spbo_pkg::ModeLoad, 16'h0012, 16'sd0, 16'sd33, 15'd16, 15'd16, '0, '0);
    send_request(spbo_pkg::ModeLoad, 16'h0013, 16'sd0, 16'sd0, 15'd16, 15'd16, 64'h8,
                 64'h0);
    send_request(spbo_pkg::ModeLoad, 16'h0014, 16'sd0, 16'sd0, 15'd16, 15'd16, 64'h0,
                 64'h8);
    send_request(spbo_pkg::ModeRun, '0, '0, '0, '0, '0, '0, '0);
    // full store, dropped loads, contact overflow
    for (int i = 0; i < 66; i++)
      send_request(spbo_pkg::ModeLoad, 16'(i), 16'sd0, 16'sd0, 15'd100, 15'd100, '0, '0);
    send_request(spbo_pkg::ModeRun, '0, '0, '0, '0, '0, '0, '0);
    // long result stall while requests keep coming
    hold_results = 1'b1;
    fork
      begin
        for (int i = 0; i < 12; i++) load_random_box(200);
        send_request(spbo_pkg::ModeRun, '0, '0, '0, '0, '0, '0, '0);
        for (int i = 0; i < 4; i++) load_random_box(200);
      end
      begin
        int held;
        held = 0;
        while (held < 400) begin
          @(posedge clk_i);
          held++;
        end
        hold_results = 1'b0;
      end
    join
    sent = 0;
    while (sent < 270) begin
      if (sent > 210) calm_phase = 1'b1;
      nb = $urandom_range(0, 9) == 0 ? $urandom_range(20, 40) : $urandom_range(0, 10);
      spread = $urandom_range(0, 3) == 0 ? 32767 : $urandom_range(16, 400);
      for (int i = 0; i < nb; i++) load_random_box(spread);
      send_request(spbo_pkg::ModeRun, 16'($urandom), 16'($urandom), 16'($urandom),
                   15'($urandom), 15'($urandom), {$urandom, $urandom},
                   {$urandom, $urandom});
      sent += nb + 1;
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
